// ----- sv/isl_pkg.sv -----
//------------------------------------------------------------------------------
// isl_pkg
// Shared types and constants for the interpolation search lookup block.
//------------------------------------------------------------------------------
package isl_pkg;

   localparam int unsigned IDX_W = 12;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_FIND  = 2'd1,
      OP_QUERY = 2'd2,
      OP_BAD   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [63:0]      key_w0;
      logic [63:0]      key_w1;
      logic [63:0]      key_w2;
      logic [63:0]      key_w3;
      logic [63:0]      new_offset;
      logic [31:0]      new_size;
      logic [31:0]      new_packed_size;
      logic [IDX_W-1:0] query_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] entry_index;
      logic [63:0]      found_offset;
      logic [31:0]      found_size;
      logic [31:0]      found_packed_size;
      logic             was_used;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_QRD,
      S_QOUT,
      S_PROBE,
      S_DIV,
      S_RD,
      S_CMP,
      S_HIT,
      S_OUT
   } state_type;

endpackage

// ----- sv/isl_div.sv -----
//------------------------------------------------------------------------------
// isl_div
// Restoring divider, one quotient bit per cycle, 64 by 32 bit.
//------------------------------------------------------------------------------
module isl_div
   import isl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;
   logic [32:0] diff;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {r_ff, q_ff[63]};
      diff    = trial - {1'b0, d_ff};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = diff[31:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign done     = busy_ff && (cnt_ff == 7'd1);
   assign quotient = q_in;

endmodule

// ----- sv/isl_store.sv -----
//------------------------------------------------------------------------------
// isl_store
// Entry memories: key, offset, sizes, used flag; one address a cycle.
//------------------------------------------------------------------------------
module isl_store
   import isl_pkg::*;
#(
   parameter int unsigned DEPTH  = 4096,
   parameter int unsigned KBITS  = 256,
   parameter int unsigned AW     = 12
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             used_we,
   input  logic             used_wd,
   input  logic [AW-1:0]    addr,
   input  logic [KBITS-1:0] wr_key,
   input  logic [63:0]      wr_offset,
   input  logic [31:0]      wr_size,
   input  logic [31:0]      wr_packed,
   output logic [KBITS-1:0] rd_key,
   output logic [63:0]      rd_offset,
   output logic [31:0]      rd_size,
   output logic [31:0]      rd_packed,
   output logic             rd_used
);

   logic [KBITS-1:0] key_mem    [DEPTH];
   logic [63:0]      offset_mem [DEPTH];
   logic [31:0]      size_mem   [DEPTH];
   logic [31:0]      packed_mem [DEPTH];
   logic             used_mem   [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[addr]    <= wr_key;
         offset_mem[addr] <= wr_offset;
         size_mem[addr]   <= wr_size;
         packed_mem[addr] <= wr_packed;
      end
      if (used_we) begin
         used_mem[addr] <= used_wd;
      end
      rd_key    <= key_mem[addr];
      rd_offset <= offset_mem[addr];
      rd_size   <= size_mem[addr];
      rd_packed <= packed_mem[addr];
      rd_used   <= used_mem[addr];
   end

endmodule

// ----- sv/interpolation_search_lookup.sv -----
//------------------------------------------------------------------------------
// interpolation_search_lookup
// Deduplication index: sorted entry table with interpolation search.
//------------------------------------------------------------------------------
// req_ carries one word per item: load entry, lookup key or query used flag.
// rsp_ returns exactly one word per item, in order.
// A load runs S_LOAD, a query S_QRD then S_QOUT. Each interpolated probe of
// a lookup runs setup in S_PROBE, the 64-step serial divider in S_DIV, one
// read of the entry memory in S_RD and a full-key compare in S_CMP; a probe
// clamped to a bound skips the divider. A hit sets its used flag in S_CMP and
// responds from S_HIT; a miss responds from S_PROBE once the bounds cross.
// Reset clears the entry count. Used flags live in a memory beside the
// entries; a load clears the flag of its entry, so every flag below the
// entry count reads zero after reset. The memories are never cleared; read
// data is used only below the entry count. One item is in work at a time;
// req_ready is high only when idle and the result register is free. A stalled
// receiver holds the result in rsp_ and the next item waits until it is taken.
//------------------------------------------------------------------------------
module interpolation_search_lookup
   import isl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 4096,
   parameter int unsigned KEY_BITS    = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] left_ff, left_in, right_ff, right_in;
   logic [AW-1:0] probe_ff, probe_in;
   logic [31:0]   nl_ff, nl_in, nr_ff, nr_in;
   logic [KEY_BITS-1:0] key;
   logic [255:0] key_full;

   logic          wr_en;
   logic          used_we, used_wd;
   logic [AW-1:0] addr;
   logic [KEY_BITS-1:0] rd_key;
   logic [63:0]   rd_offset;
   logic [31:0]   rd_size, rd_packed;
   logic          rd_used;

   logic          div_start, div_done;
   logic [63:0]   div_q;
   logic [31:0]   nk;
   logic [CW-1:0] span;
   logic [CW-1:0] probe_full;

   assign key_full = {req_ff.key_w0, req_ff.key_w1, req_ff.key_w2, req_ff.key_w3};
   assign key      = key_full[255 -: KEY_BITS];
   assign nk       = req_ff.key_w0[63:32];
   assign span     = right_ff - left_ff - CW'(1);

   isl_store #(.DEPTH(TABLE_DEPTH), .KBITS(KEY_BITS), .AW(AW)) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .used_we   (used_we),
      .used_wd   (used_wd),
      .addr      (addr),
      .wr_key    (key),
      .wr_offset (req_ff.new_offset),
      .wr_size   (req_ff.new_size),
      .wr_packed (req_ff.new_packed_size),
      .rd_key    (rd_key),
      .rd_offset (rd_offset),
      .rd_size   (rd_size),
      .rd_packed (rd_packed),
      .rd_used   (rd_used)
   );

   isl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (64'(span) * 64'(nk - nl_ff)),
      .divisor  (nr_ff - nl_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      probe_in     = probe_ff;
      nl_in        = nl_ff;
      nr_in        = nr_ff;
      wr_en        = 1'b0;
      used_we      = 1'b0;
      used_wd      = 1'b0;
      addr         = probe_ff;
      div_start    = 1'b0;
      probe_full   = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in   = req_data;
               rsp_in   = '0;
               left_in  = '0;
               right_in = count_ff;
               nl_in    = '0;
               nr_in    = '1;
               unique case (op_type'(req_data.op))
                  OP_LOAD:  state_in = S_LOAD;
                  OP_FIND:  state_in = S_PROBE;
                  OP_QUERY: state_in = S_QRD;
                  default: begin
                     rsp_in.status = ST_RANGE;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         S_LOAD: begin
            if (count_ff == CW'(TABLE_DEPTH)) begin
               rsp_in.status = ST_FULL;
            end else begin
               addr               = count_ff[AW-1:0];
               wr_en              = 1'b1;
               used_we            = 1'b1;
               rsp_in.entry_index = IDX_W'(count_ff);
               count_in           = count_ff + CW'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_QRD: begin
            addr     = AW'(req_ff.query_index);
            state_in = S_QOUT;
         end
         S_QOUT: begin
            if (32'(req_ff.query_index) >= 32'(count_ff)) begin
               rsp_in.status = ST_RANGE;
            end else begin
               rsp_in.entry_index = req_ff.query_index;
               rsp_in.was_used    = rd_used;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_PROBE: begin
            if (right_ff <= left_ff) begin
               rsp_in.status = ST_NOT_FOUND;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (nk <= nl_ff || nl_ff >= nr_ff) begin
               probe_in = left_ff[AW-1:0];
               state_in = S_RD;
            end else if (nk >= nr_ff) begin
               probe_full = right_ff - CW'(1);
               probe_in   = probe_full[AW-1:0];
               state_in   = S_RD;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               probe_full = left_ff + CW'(div_q);
               probe_in   = probe_full[AW-1:0];
               state_in   = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (rd_key < key) begin
               left_in  = CW'(probe_ff) + CW'(1);
               nl_in    = rd_key[KEY_BITS-1 -: 32];
               state_in = S_PROBE;
            end else if (rd_key > key) begin
               right_in = CW'(probe_ff);
               nr_in    = rd_key[KEY_BITS-1 -: 32];
               state_in = S_PROBE;
            end else begin
               rsp_in.entry_index       = IDX_W'(probe_ff);
               rsp_in.found_offset      = rd_offset;
               rsp_in.found_size        = rd_size;
               rsp_in.found_packed_size = rd_packed;
               rsp_in.was_used          = rd_used;
               used_we                  = 1'b1;
               used_wd                  = 1'b1;
               state_in                 = S_HIT;
            end
         end
         S_HIT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      probe_ff <= probe_in;
      nl_ff    <= nl_in;
      nr_ff    <= nr_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ----- verif/tb_interpolation_search_lookup.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_interpolation_search_lookup
// Self-checking bench: directed table then random loads, lookups, queries
// and bad ops; every response word is checked against an in-bench index model.
//------------------------------------------------------------------------------
module tb_interpolation_search_lookup;
   import isl_pkg::*;

   localparam int unsigned DEPTH = 4096;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_ready = 1'b0;
   logic    rsp_valid;
   rsp_type rsp_data;

   interpolation_search_lookup dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_ready(rsp_ready), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // index model
   logic [255:0] idx_key [DEPTH];
   logic [63:0]  idx_offset [DEPTH];
   logic [31:0]  idx_blk_size [DEPTH];
   logic [31:0]  idx_packed [DEPTH];
   logic         idx_used [DEPTH];
   int unsigned  idx_count;

   rsp_type     pending_rsp [$];
   int unsigned errors;
   int unsigned words_in, words_out, hits, misses;
   bit          quiet;
   int          idle_pct;

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type      o;
      logic [255:0] k;
      logic [31:0]  nk, nl, nr, lo, hi, n, probe;
      o = '0;
      k = {r.key_w0, r.key_w1, r.key_w2, r.key_w3};
      case (op_type'(r.op))
         OP_LOAD: begin
            if (idx_count >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               idx_key[idx_count]      = k;
               idx_offset[idx_count]   = r.new_offset;
               idx_blk_size[idx_count] = r.new_size;
               idx_packed[idx_count]   = r.new_packed_size;
               o.entry_index = idx_count[IDX_W-1:0];
               idx_count++;
            end
         end
         OP_FIND: begin
            nk = r.key_w0[63:32];
            nl = 0;
            nr = 32'hFFFF_FFFF;
            lo = 0;
            hi = idx_count;
            o.status = ST_NOT_FOUND;
            while (hi > lo) begin
               n = hi - lo;
               if (nk <= nl || nl >= nr) probe = lo;
               else if (nk >= nr) probe = hi - 1;
               else probe = lo + 32'((64'(n - 1) * 64'(nk - nl)) / 64'(nr - nl));
               if (idx_key[probe] < k) begin
                  lo = probe + 1;
                  nl = idx_key[probe][255:224];
               end else if (idx_key[probe] > k) begin
                  hi = probe;
                  nr = idx_key[probe][255:224];
               end else begin
                  o.status = ST_OK;
                  o.entry_index = probe[IDX_W-1:0];
                  o.found_offset = idx_offset[probe];
                  o.found_size = idx_blk_size[probe];
                  o.found_packed_size = idx_packed[probe];
                  o.was_used = idx_used[probe];
                  idx_used[probe] = 1'b1;
                  break;
               end
            end
         end
         OP_QUERY: begin
            if (r.query_index >= idx_count) begin
               o.status = ST_RANGE;
            end else begin
               o.entry_index = r.query_index;
               o.was_used = idx_used[r.query_index];
            end
         end
         default: o.status = ST_RANGE;
      endcase
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type make_req(op_type op, logic [255:0] k, logic [IDX_W-1:0] q);
      req_type r;
      r.op = op;
      {r.key_w0, r.key_w1, r.key_w2, r.key_w3} = k;
      r.new_offset = rand64();
      r.new_size = $urandom;
      r.new_packed_size = $urandom;
      r.query_index = q;
      return r;
   endfunction

   task automatic send_word(req_type r);
      if (!quiet && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while (!quiet && $urandom_range(99) < idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(predict_rsp(r));
      if (r.op == OP_FIND) words_in++;
      @(negedge clock);
   endtask

   always @(negedge clock)
      if (!reset) rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         words_out++;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected word: actual %p", $time, rsp_data);
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (e.status == ST_OK && rsp_data.found_offset != 0) hits++;
            if (e.status == ST_NOT_FOUND) misses++;
            if (e !== rsp_data) begin
               errors++;
               $display("%0t mismatch: expected %p actual %p", $time, e, rsp_data);
            end
         end
      end
   end

   initial begin
      #2000ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   typedef struct {
      op_type           op;
      logic [255:0]     key;
      logic [IDX_W-1:0] q;
      bit               typed;
      status_type       st;
      logic [IDX_W-1:0] idx;
   } dir_row;

   dir_row          dir_tab [$];
   logic [255:0]    base, kk;
   logic [255:0]    loaded [$];
   req_type         r;
   rsp_type         e;
   int              n;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         idx_used[i] = 1'b0;
         idx_key[i] = '0;
      end
      idx_count = 0;
      idle_pct = 38;
      quiet = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, unknown op, equal bounds
      dir_tab.push_back('{OP_FIND, '0, 0, 1, ST_NOT_FOUND, 0});
      dir_tab.push_back('{OP_QUERY, '0, 0, 1, ST_RANGE, 0});
      dir_tab.push_back('{OP_BAD, '1, 12'hFFF, 1, ST_RANGE, 0});
      dir_tab.push_back('{OP_LOAD, '0, 0, 1, ST_OK, 0});
      dir_tab.push_back('{OP_LOAD, {32'h0, 224'h5}, 0, 1, ST_OK, 1});
      dir_tab.push_back('{OP_LOAD, {32'h8000_0000, 224'h0}, 0, 1, ST_OK, 2});
      dir_tab.push_back('{OP_LOAD, {32'h8000_0000, 224'h7}, 0, 1, ST_OK, 3});
      dir_tab.push_back('{OP_LOAD, '1, 0, 1, ST_OK, 4});
      dir_tab.push_back('{OP_FIND, '0, 0, 0, ST_OK, 0});
      dir_tab.push_back('{OP_FIND, '0, 0, 0, ST_OK, 0});
      dir_tab.push_back('{OP_FIND, '1, 0, 0, ST_OK, 0});
      dir_tab.push_back('{OP_FIND, {32'h0, 224'h5}, 0, 0, ST_OK, 0});
      dir_tab.push_back('{OP_FIND, {32'h8000_0000, 224'h7}, 0, 0, ST_OK, 0});
      dir_tab.push_back('{OP_FIND, {32'h8000_0000, 224'h3}, 0, 0, ST_OK, 0});
      dir_tab.push_back('{OP_FIND, {32'hFFFF_FFFF, 224'h0}, 0, 0, ST_OK, 0});
      dir_tab.push_back('{OP_QUERY, '0, 0, 0, ST_OK, 0});
      dir_tab.push_back('{OP_QUERY, '0, 4, 0, ST_OK, 0});
      dir_tab.push_back('{OP_QUERY, '0, 1, 0, ST_OK, 0});
      dir_tab.push_back('{OP_QUERY, '0, 5, 1, ST_RANGE, 0});
      dir_tab.push_back('{OP_QUERY, '0, 12'hFFF, 1, ST_RANGE, 0});
      foreach (dir_tab[i]) begin
         r = make_req(dir_tab[i].op, dir_tab[i].key, dir_tab[i].q);
         if (dir_tab[i].typed) begin
            e = '0;
            e.status = dir_tab[i].st;
            e.entry_index = dir_tab[i].idx;
            // typed row: cross-check the predictor first
            begin
               rsp_type p;
               p = predict_rsp(r);
               if (p !== e) begin
                  errors++;
                  $display("%0t mismatch: expected %p actual %p", $time, e, p);
               end
               idx_count = idx_count - (r.op == OP_LOAD ? 1 : 0);
            end
         end
         send_word(r);
      end
      for (int i = 0; i <= 4; i++) loaded.push_back(idx_key[i]);

      // random: loads mostly ascending, mostly stored-key lookups, some noise
      base = {32'h8000_0001, 224'h0};
      for (int i = 0; i < 880; i++) begin
         quiet = (i >= 300 && i < 420);
         n = $urandom_range(99);
         if (n < 25 && idx_count < DEPTH) begin
            if ($urandom_range(9) == 0) base[255:224] = base[255:224] + 1;
            else if ($urandom_range(3) == 0)
               base = base + {$urandom_range(1 << 20), 192'h0, 32'($urandom)};
            else base = base + {rand64(), rand64()};
            if (base[255:224] == 32'hFFFF_FFFF) base = '0;
            kk = ($urandom_range(19) == 0) ? {rand64(), rand64(), rand64(), rand64()} : base;
            loaded.push_back(kk);
            send_word(make_req(OP_LOAD, kk, '0));
         end else if (n < 75) begin
            kk = loaded[$urandom_range(loaded.size() - 1)];
            send_word(make_req(OP_FIND, kk, '0));
         end else if (n < 85) begin
            kk = {rand64(), rand64(), rand64(), rand64()};
            if ($urandom_range(1)) kk = loaded[$urandom_range(loaded.size() - 1)] ^ 256'h1;
            send_word(make_req(OP_FIND, kk, '0));
         end else if (n < 97) begin
            send_word(make_req(OP_QUERY, '0, 12'($urandom_range(idx_count + 3 < DEPTH ?
                                                            idx_count + 3 : DEPTH - 1))));
         end else begin
            send_word(make_req($urandom_range(1) ? OP_BAD : OP_QUERY, '1, 12'($urandom)));
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d lookups (%0d hits, %0d misses) across %0d table entries.",
               words_in, hits, misses, idx_count);
      $display("%0d response words checked, %0d errors.", words_out, errors);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
